>>> rtl/dlsq_pkg.sv
`timescale 1ns / 1ps

package dlsq_pkg;

  // Queue geometry.
  localparam int QUEUE_DEPTH = 64;
  localparam int TICK_WIDTH  = 16;
  localparam int MAX_RESULTS = 64;

  // Field widths of the words on the channels.
  localparam int CMD_W  = 2;
  localparam int ID_W   = 6;
  localparam int WAIT_W = 16;
  localparam int KIND_W = 3;

  // Derived widths: a count or position must hold the depth itself.
  localparam int POS_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REL_W = $clog2(MAX_RESULTS + 1);

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERTED  = 3'd0,
    KIND_IGNORED   = 3'd1,
    KIND_FULL      = 3'd2,
    KIND_REMOVED   = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_RELEASED  = 3'd5
  } kind_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    C_IDLE,
    C_LOAD,
    C_INS_STEP,
    C_REM_STEP,
    C_TICK_DEC,
    C_POP
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_REM_WALK,
    S_RELEASE,
    S_EMIT
  } state_t;

  // Control shared by all cells.
  typedef struct packed {
    cell_op_t              op;
    logic [ID_W-1:0]       id;
    logic [TICK_WIDTH-1:0] rem;
    logic [POS_W-1:0]      pos;
    logic                  at_end;
  } cell_ctl_t;

  // What a cell shows to one of its neighbors.
  typedef struct packed {
    logic                  tok;
    logic [ID_W-1:0]       id;
    logic [TICK_WIDTH-1:0] delta;
    logic [TICK_WIDTH-1:0] rem;
  } cell_link_t;

endpackage

>>> rtl/dlsq_in_if.sv
`timescale 1ns / 1ps

interface dlsq_in_if;
  logic                        valid;
  logic                        ready;
  logic [dlsq_pkg::CMD_W-1:0]  command;
  logic [dlsq_pkg::ID_W-1:0]   thread_id;
  logic [dlsq_pkg::WAIT_W-1:0] wait_ticks;

  modport source (output valid, command, thread_id, wait_ticks, input ready);
  modport sink (input valid, command, thread_id, wait_ticks, output ready);
endinterface

>>> rtl/dlsq_out_if.sv
`timescale 1ns / 1ps

interface dlsq_out_if;
  logic                        valid;
  logic                        ready;
  logic [dlsq_pkg::KIND_W-1:0] event_kind;
  logic [dlsq_pkg::ID_W-1:0]   released_id;
  logic                        nothing_released;
  logic                        last;

  modport source (output valid, event_kind, released_id, nothing_released, last,
                  input ready);
  modport sink (input valid, event_kind, released_id, nothing_released, last,
                output ready);
endinterface

>>> rtl/dlsq_cell.sv
`timescale 1ns / 1ps

// One entry of the delta list. A walk token and its remaining wait move
// one cell to the right per cycle; shifts move whole entries between
// neighbors.
module dlsq_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dlsq_pkg::POS_W-1:0]    idx,
  input  dlsq_pkg::cell_ctl_t           ctl,
  input  logic                          row_hit,
  input  dlsq_pkg::cell_link_t          left_in,
  input  dlsq_pkg::cell_link_t          right_in,
  output dlsq_pkg::cell_link_t          fwd_out,
  output dlsq_pkg::cell_link_t          back_out,
  output logic                          hit
);

  logic                            tok_r;
  logic                            tok_nxt;
  logic [dlsq_pkg::TICK_WIDTH-1:0] rem_r;
  logic [dlsq_pkg::TICK_WIDTH-1:0] rem_nxt;
  logic [dlsq_pkg::ID_W-1:0]       id_r;
  logic [dlsq_pkg::ID_W-1:0]       id_nxt;
  logic [dlsq_pkg::TICK_WIDTH-1:0] delta_r;
  logic [dlsq_pkg::TICK_WIDTH-1:0] delta_nxt;
  logic                            stop_ins;
  logic                            match;
  logic [dlsq_pkg::TICK_WIDTH:0]   sum;
  logic [dlsq_pkg::TICK_WIDTH-1:0] sum_sat;

  // Local decisions of the cell that holds the token.
  assign stop_ins = tok_r & (ctl.at_end | (delta_r >= rem_r));
  assign match    = tok_r & ~ctl.at_end & (id_r == ctl.id);
  assign sum      = {1'b0, right_in.delta} + {1'b0, delta_r};
  assign sum_sat  = sum[dlsq_pkg::TICK_WIDTH] ? dlsq_pkg::TICK_MAX
                                              : sum[dlsq_pkg::TICK_WIDTH-1:0];

  assign hit = ((ctl.op == dlsq_pkg::C_INS_STEP) & stop_ins) |
               ((ctl.op == dlsq_pkg::C_REM_STEP) & match);

  // The right neighbor sees this delta already reduced by a new entry placed here.
  assign fwd_out.tok   = tok_r;
  assign fwd_out.id    = id_r;
  assign fwd_out.delta = tok_r ? (delta_r - rem_r) : delta_r;
  assign fwd_out.rem   = rem_r - delta_r;

  assign back_out.tok   = tok_r;
  assign back_out.id    = id_r;
  assign back_out.delta = delta_r;
  assign back_out.rem   = rem_r;

  // Next state of the entry and of the walk token.
  always_comb begin
    tok_nxt   = tok_r;
    rem_nxt   = rem_r;
    id_nxt    = id_r;
    delta_nxt = delta_r;
    case (ctl.op)
      dlsq_pkg::C_LOAD: begin
        tok_nxt = (idx == '0);
        rem_nxt = ctl.rem;
      end
      dlsq_pkg::C_INS_STEP: begin
        if (row_hit) begin
          tok_nxt = 1'b0;
          if (tok_r) begin
            id_nxt    = ctl.id;
            delta_nxt = rem_r;
          end else if (idx > ctl.pos) begin
            id_nxt    = left_in.id;
            delta_nxt = left_in.delta;
          end
        end else begin
          tok_nxt = left_in.tok;
          rem_nxt = left_in.rem;
        end
      end
      dlsq_pkg::C_REM_STEP: begin
        if (row_hit) begin
          tok_nxt = 1'b0;
          if (idx >= ctl.pos) begin
            id_nxt    = right_in.id;
            delta_nxt = tok_r ? sum_sat : right_in.delta;
          end
        end else begin
          tok_nxt = left_in.tok;
        end
      end
      dlsq_pkg::C_TICK_DEC: begin
        if ((idx == '0) && (delta_r != '0)) begin
          delta_nxt = delta_r - 1'b1;
        end
      end
      dlsq_pkg::C_POP: begin
        id_nxt    = right_in.id;
        delta_nxt = right_in.delta;
      end
      default: begin
        tok_nxt = tok_r;
      end
    endcase
  end

  // Token register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // Entry and remaining wait.
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    id_r    <= id_nxt;
    delta_r <= delta_nxt;
  end

endmodule

>>> rtl/delta_list_sleep_queue.sv
`timescale 1ns / 1ps

// Channel   Direction  Word fields
// in_ch     sink       command, thread_id, wait_ticks
// out_ch    source     event_kind, released_id, nothing_released, last
//
// Insert and remove walk a token along the row from cell 0 until it stops, and
// the token moves one cell per cycle. A tick gives one word per released thread,
// or one word when none is released. An ignored or refused insert gives one word;
// an unknown command gives no word. The next word is taken in the cycle after the
// last load. Reset empties the queue at once, and a stalled output holds its word
// while the row waits.
module delta_list_sleep_queue (
  input logic         clk,
  input logic         rst_n,
  dlsq_in_if.sink     in_ch,
  dlsq_out_if.source  out_ch
);

  localparam int D = dlsq_pkg::QUEUE_DEPTH;

  dlsq_pkg::state_t                state_r;
  dlsq_pkg::state_t                state_nxt;
  logic [dlsq_pkg::POS_W-1:0]      pos_r;
  logic [dlsq_pkg::POS_W-1:0]      pos_nxt;
  logic [dlsq_pkg::POS_W-1:0]      count_r;
  logic [dlsq_pkg::POS_W-1:0]      count_nxt;
  logic [dlsq_pkg::REL_W-1:0]      n_r;
  logic [dlsq_pkg::REL_W-1:0]      n_nxt;
  logic [dlsq_pkg::ID_W-1:0]       id_in_r;
  logic [dlsq_pkg::ID_W-1:0]       id_in_nxt;
  dlsq_pkg::kind_t                 kind_r;
  dlsq_pkg::kind_t                 kind_nxt;

  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic [dlsq_pkg::KIND_W-1:0]     out_kind_r;
  logic [dlsq_pkg::KIND_W-1:0]     out_kind_nxt;
  logic [dlsq_pkg::ID_W-1:0]       out_id_r;
  logic [dlsq_pkg::ID_W-1:0]       out_id_nxt;
  logic                            out_none_r;
  logic                            out_none_nxt;
  logic                            out_last_r;
  logic                            out_last_nxt;

  dlsq_pkg::cell_ctl_t             ctl;
  dlsq_pkg::cell_link_t            fwd [D];
  dlsq_pkg::cell_link_t            back [D];
  logic [D-1:0]                    hit_vec;
  logic                            row_hit;
  logic                            can_load;
  logic                            head_zero;
  logic                            rel_last;
  logic [31:0]                     wait_wide;
  logic [dlsq_pkg::TICK_WIDTH-1:0] wait_sat;

  // Row of cells, each wired to both neighbors.
  for (genvar i = 0; i < D; i++) begin : g_cell
    dlsq_pkg::cell_link_t left_link;
    dlsq_pkg::cell_link_t right_link;
    if (i == 0) begin : g_first
      assign left_link = '0;
    end else begin : g_mid_l
      assign left_link = fwd[i-1];
    end
    if (i == D - 1) begin : g_last
      assign right_link = '0;
    end else begin : g_mid_r
      assign right_link = back[i+1];
    end
    dlsq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (dlsq_pkg::POS_W'(i)),
      .ctl      (ctl),
      .row_hit  (row_hit),
      .left_in  (left_link),
      .right_in (right_link),
      .fwd_out  (fwd[i]),
      .back_out (back[i]),
      .hit      (hit_vec[i])
    );
  end

  // Some cell has stopped the walk this cycle.
  assign row_hit = |hit_vec;

  // Requested wait clipped to the delta width.
  assign wait_wide = 32'(in_ch.wait_ticks);
  assign wait_sat  = (wait_wide > 32'(dlsq_pkg::TICK_MAX)) ? dlsq_pkg::TICK_MAX
                                                           : wait_wide[dlsq_pkg::TICK_WIDTH-1:0];

  assign can_load  = ~out_valid_r | out_ch.ready;
  assign head_zero = (count_r != '0) && (back[0].delta == '0) &&
                     (n_r < dlsq_pkg::REL_W'(dlsq_pkg::MAX_RESULTS));
  assign rel_last  = (count_r == dlsq_pkg::POS_W'(1)) || (back[1].delta != '0) ||
                     (n_r == dlsq_pkg::REL_W'(dlsq_pkg::MAX_RESULTS - 1));

  assign in_ch.ready = (state_r == dlsq_pkg::S_IDLE);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.event_kind       = out_kind_r;
  assign out_ch.released_id      = out_id_r;
  assign out_ch.nothing_released = out_none_r;
  assign out_ch.last             = out_last_r;

  // Operation and walk control broadcast to the row.
  always_comb begin
    ctl.op     = dlsq_pkg::C_IDLE;
    ctl.id     = id_in_r;
    ctl.rem    = wait_sat;
    ctl.pos    = pos_r;
    ctl.at_end = (pos_r >= count_r);

    case (state_r)
      dlsq_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          case (dlsq_pkg::cmd_t'(in_ch.command))
            dlsq_pkg::CMD_INSERT: begin
              if ((in_ch.wait_ticks != '0) && (count_r != dlsq_pkg::POS_W'(D))) begin
                ctl.op = dlsq_pkg::C_LOAD;
              end
            end
            dlsq_pkg::CMD_REMOVE: begin
              ctl.op = dlsq_pkg::C_LOAD;
            end
            dlsq_pkg::CMD_TICK: begin
              if (count_r != '0) begin
                ctl.op = dlsq_pkg::C_TICK_DEC;
              end
            end
            default: begin
              ctl.op = dlsq_pkg::C_IDLE;
            end
          endcase
        end
      end
      dlsq_pkg::S_INS_WALK: begin
        ctl.op = dlsq_pkg::C_INS_STEP;
      end
      dlsq_pkg::S_REM_WALK: begin
        if (pos_r < count_r) begin
          ctl.op = dlsq_pkg::C_REM_STEP;
        end
      end
      dlsq_pkg::S_RELEASE: begin
        if (can_load && head_zero) begin
          ctl.op = dlsq_pkg::C_POP;
        end
      end
      default: begin
        ctl.op = dlsq_pkg::C_IDLE;
      end
    endcase
  end

  // Sequencer: next state and output register loads.
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    id_in_nxt     = id_in_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_none_nxt  = out_none_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      dlsq_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          id_in_nxt = in_ch.thread_id;
          pos_nxt   = '0;
          n_nxt     = '0;
          case (dlsq_pkg::cmd_t'(in_ch.command))
            dlsq_pkg::CMD_INSERT: begin
              if (in_ch.wait_ticks == '0) begin
                kind_nxt  = dlsq_pkg::KIND_IGNORED;
                state_nxt = dlsq_pkg::S_EMIT;
              end else if (count_r == dlsq_pkg::POS_W'(D)) begin
                kind_nxt  = dlsq_pkg::KIND_FULL;
                state_nxt = dlsq_pkg::S_EMIT;
              end else begin
                state_nxt = dlsq_pkg::S_INS_WALK;
              end
            end
            dlsq_pkg::CMD_REMOVE: begin
              state_nxt = dlsq_pkg::S_REM_WALK;
            end
            dlsq_pkg::CMD_TICK: begin
              state_nxt = dlsq_pkg::S_RELEASE;
            end
            default: begin
              state_nxt = dlsq_pkg::S_IDLE;
            end
          endcase
        end
      end
      dlsq_pkg::S_INS_WALK: begin
        if (row_hit) begin
          count_nxt = count_r + 1'b1;
          kind_nxt  = dlsq_pkg::KIND_INSERTED;
          state_nxt = dlsq_pkg::S_EMIT;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      dlsq_pkg::S_REM_WALK: begin
        if (ctl.at_end) begin
          kind_nxt  = dlsq_pkg::KIND_NOT_FOUND;
          state_nxt = dlsq_pkg::S_EMIT;
        end else begin
          if (row_hit) begin
            count_nxt = count_r - 1'b1;
            kind_nxt  = dlsq_pkg::KIND_REMOVED;
            state_nxt = dlsq_pkg::S_EMIT;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      dlsq_pkg::S_RELEASE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dlsq_pkg::KIND_RELEASED;
          if (head_zero) begin
            // Pop the head and report it.
            out_id_nxt   = back[0].id;
            out_none_nxt = 1'b0;
            out_last_nxt = rel_last;
            count_nxt    = count_r - 1'b1;
            n_nxt        = n_r + 1'b1;
            if (rel_last) begin
              state_nxt = dlsq_pkg::S_IDLE;
            end
          end else begin
            // A tick that released nothing.
            out_id_nxt   = '0;
            out_none_nxt = 1'b1;
            out_last_nxt = 1'b1;
            state_nxt    = dlsq_pkg::S_IDLE;
          end
        end
      end
      dlsq_pkg::S_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_id_nxt    = id_in_r;
          out_none_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = dlsq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dlsq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlsq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and output word registers.
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    n_r        <= n_nxt;
    id_in_r    <= id_in_nxt;
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_none_r <= out_none_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> bench/tb_delta_list_sleep_queue.sv
`timescale 1ns / 1ps

module tb_delta_list_sleep_queue;
  import dlsq_pkg::*;

  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT = 2000;
  // Settling time after the last result: longer than the longest walk.
  localparam int TAIL_CYCLES = 150;

  typedef struct {
    kind_t           kind;
    logic [ID_W-1:0] id;
    logic            none;
    logic            last;
  } sleep_event_t;

  logic clk;
  logic rst_n;

  dlsq_in_if  in_ch ();
  dlsq_out_if out_ch ();

  delta_list_sleep_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the sleep queue, kept as the same delta list.
  logic [ID_W-1:0]       sleeper_id [QUEUE_DEPTH];
  logic [TICK_WIDTH-1:0] sleeper_delta [QUEUE_DEPTH];
  int                    sleeper_count;

  sleep_event_t pending_events [$];
  sleep_event_t head_event;

  int          errors;
  int          words_sent;
  int          events_checked;
  int          threads_released;
  int          full_refusals;
  int          idle_ticks;
  int          missing_removes;
  int          idle_cycles;
  int unsigned out_stall;
  bit          no_idle;

  // Clock.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic push_event(input kind_t kind, input logic [ID_W-1:0] id,
                            input logic none, input logic last);
    sleep_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.none = none;
    ev.last = last;
    pending_events.push_back(ev);
  endtask

  // Update the shadow queue for one accepted word and queue the events it causes.
  task automatic predict_sleep_queue(input cmd_t cmd, input logic [ID_W-1:0] id,
                                     input logic [WAIT_W-1:0] wait_ticks);
    int                    pos;
    int                    n;
    logic [TICK_WIDTH-1:0] rem;
    logic [TICK_WIDTH:0]   sum;
    case (cmd)
      CMD_INSERT: begin
        if (wait_ticks == '0) begin
          push_event(KIND_IGNORED, id, 1'b0, 1'b1);
        end else if (sleeper_count >= QUEUE_DEPTH) begin
          push_event(KIND_FULL, id, 1'b0, 1'b1);
        end else begin
          rem = TICK_WIDTH'(wait_ticks);
          pos = 0;
          // Walk past strictly smaller deltas; the new entry goes ahead of equal ones.
          while (pos < sleeper_count && sleeper_delta[pos] < rem) begin
            rem = rem - sleeper_delta[pos];
            pos++;
          end
          if (pos < sleeper_count) sleeper_delta[pos] = sleeper_delta[pos] - rem;
          for (int i = sleeper_count; i > pos; i--) begin
            sleeper_id[i]    = sleeper_id[i-1];
            sleeper_delta[i] = sleeper_delta[i-1];
          end
          sleeper_id[pos]    = id;
          sleeper_delta[pos] = rem;
          sleeper_count++;
          push_event(KIND_INSERTED, id, 1'b0, 1'b1);
        end
      end
      CMD_REMOVE: begin
        pos = 0;
        while (pos < sleeper_count && sleeper_id[pos] != id) pos++;
        if (pos >= sleeper_count) begin
          push_event(KIND_NOT_FOUND, id, 1'b0, 1'b1);
        end else begin
          // The successor inherits the removed delta, saturating at the tick maximum.
          if (pos + 1 < sleeper_count) begin
            sum = {1'b0, sleeper_delta[pos+1]} + {1'b0, sleeper_delta[pos]};
            sleeper_delta[pos+1] = sum[TICK_WIDTH] ? TICK_MAX : sum[TICK_WIDTH-1:0];
          end
          for (int i = pos; i + 1 < sleeper_count; i++) begin
            sleeper_id[i]    = sleeper_id[i+1];
            sleeper_delta[i] = sleeper_delta[i+1];
          end
          sleeper_count--;
          push_event(KIND_REMOVED, id, 1'b0, 1'b1);
        end
      end
      CMD_TICK: begin
        if (sleeper_count > 0 && sleeper_delta[0] != '0)
          sleeper_delta[0] = sleeper_delta[0] - 1'b1;
        n = 0;
        while (n < sleeper_count && n < MAX_RESULTS && sleeper_delta[n] == '0) n++;
        if (n == 0) begin
          push_event(KIND_RELEASED, '0, 1'b1, 1'b1);
        end else begin
          for (int k = 0; k < n; k++)
            push_event(KIND_RELEASED, sleeper_id[k], 1'b0, k == n - 1);
          for (int i = 0; i + n < sleeper_count; i++) begin
            sleeper_id[i]    = sleeper_id[i+n];
            sleeper_delta[i] = sleeper_delta[i+n];
          end
          sleeper_count -= n;
        end
      end
      default: ;
    endcase
  endtask

  // Present one word after a random gap and hold it until it is taken.
  task automatic send_word(input cmd_t cmd, input logic [ID_W-1:0] id,
                           input logic [WAIT_W-1:0] wait_ticks);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.thread_id  <= id;
    in_ch.wait_ticks <= wait_ticks;
    do @(posedge clk); while (!in_ch.ready);
    predict_sleep_queue(cmd, id, wait_ticks);
    words_sent++;
  endtask

  // Stop sending until every expected event has come back.
  task automatic wait_events_drained;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  // Directed corner cases on a nearly empty queue.
  task automatic test_edge_cases;
    send_word(CMD_TICK, 6'd0, 16'h0000);     // tick with nothing queued
    send_word(CMD_REMOVE, 6'd63, 16'h0000);  // missing id
    send_word(CMD_INSERT, 6'd63, 16'h0000);  // zero wait is ignored
    send_word(CMD_INSERT, 6'd0, 16'hFFFF);   // longest wait
    send_word(CMD_INSERT, 6'd63, 16'h0001);
    send_word(CMD_INSERT, 6'd21, 16'h0005);
    send_word(CMD_INSERT, 6'd42, 16'h0005);  // equal delta goes ahead
    send_word(CMD_INSERT, 6'd42, 16'h0003);  // duplicate id
    send_word(CMD_REMOVE, 6'd42, 16'h0000);  // only the first match leaves
    send_word(CMD_REMOVE, 6'd42, 16'h0000);
    send_word(CMD_NONE, 6'd42, 16'h5555);    // unknown command, no event
    send_word(CMD_INSERT, 6'd7, 16'hAAAA);
    wait_events_drained();
    send_word(CMD_REMOVE, 6'd0, 16'h0000);   // tail entry, no successor
    send_word(CMD_REMOVE, 6'd21, 16'h0000);  // successor takes its delta
    for (int i = 0; i < 6; i++) send_word(CMD_TICK, 6'd0, 16'h0000);
    send_word(CMD_REMOVE, 6'd7, 16'h0000);
    send_word(CMD_TICK, 6'd0, 16'h0000);
    wait_events_drained();
  endtask

  // Fill the queue so that every entry wakes on the same tick.
  task automatic test_full_queue;
    no_idle = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (i == QUEUE_DEPTH / 2) no_idle = 1'b0;
      send_word(CMD_INSERT, ID_W'($urandom_range(0, 63)), 16'h0001);
    end
    send_word(CMD_INSERT, 6'd63, 16'hFFFF);   // refused, queue full
    send_word(CMD_INSERT, 6'd12, 16'h0000);   // zero wait wins over full
    send_word(CMD_TICK, 6'd0, 16'h0000);      // releases the whole queue
    send_word(CMD_TICK, 6'd0, 16'h0000);
    wait_events_drained();
    no_idle = 1'b0;
  endtask

  // Mixed inserts, removes, ticks and unknown commands, mostly with short waits so that threads wake often.
  task automatic test_random_traffic(input int count);
    int              pick;
    logic [ID_W-1:0] id;
    logic [WAIT_W-1:0] wait_ticks;
    for (int n = 0; n < count; n++) begin
      if (n % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (n % 60 == 59) wait_events_drained();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        id = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7))
                                         : ID_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        if (pick < 7)      wait_ticks = WAIT_W'($urandom_range(1, 12));
        else if (pick < 9) wait_ticks = WAIT_W'($urandom_range(0, 65535));
        else               wait_ticks = '0;
        send_word(CMD_INSERT, id, wait_ticks);
      end else if (pick < 65) begin
        if (sleeper_count > 0 && $urandom_range(0, 9) < 7)
          id = sleeper_id[$urandom_range(0, sleeper_count - 1)];
        else
          id = ID_W'($urandom_range(0, 63));
        send_word(CMD_REMOVE, id, WAIT_W'($urandom_range(0, 65535)));
      end else if (pick < 97) begin
        send_word(CMD_TICK, ID_W'($urandom_range(0, 63)), WAIT_W'($urandom_range(0, 65535)));
      end else begin
        send_word(CMD_NONE, ID_W'($urandom_range(0, 63)), WAIT_W'($urandom_range(0, 65535)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Result side: check each word and draw the stall before the next one.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d id %0d",
                 $time, out_ch.event_kind, out_ch.released_id);
        errors++;
      end else begin
        head_event = pending_events.pop_front();
        check_field("event_kind", int'(head_event.kind), int'(out_ch.event_kind));
        check_field("released_id", int'(head_event.id), int'(out_ch.released_id));
        check_field("nothing_released", int'(head_event.none),
                    int'(out_ch.nothing_released));
        check_field("last", int'(head_event.last), int'(out_ch.last));
      end
      events_checked++;
      if (out_ch.event_kind == KIND_RELEASED && !out_ch.nothing_released) threads_released++;
      if (out_ch.event_kind == KIND_RELEASED && out_ch.nothing_released) idle_ticks++;
      if (out_ch.event_kind == KIND_FULL) full_refusals++;
      if (out_ch.event_kind == KIND_NOT_FOUND) missing_removes++;
      out_stall <= no_idle ? 0 : $urandom_range(0, 15);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && (out_stall == 0);
  end

  // Watchdog on handshake activity.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_NONE;
    in_ch.thread_id  = '0;
    in_ch.wait_ticks = '0;
    out_ch.ready     = 1'b0;
    sleeper_count    = 0;
    errors           = 0;
    words_sent       = 0;
    events_checked   = 0;
    threads_released = 0;
    full_refusals    = 0;
    idle_ticks       = 0;
    missing_removes  = 0;
    idle_cycles      = 0;
    out_stall        = 0;
    no_idle          = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_full_queue();
    test_random_traffic(190);

    wait_events_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words and checked %0d events: %0d threads released, %0d idle ticks.",
             words_sent, events_checked, threads_released, idle_ticks);
    $display("Queue-full refusals: %0d, removes of missing threads: %0d.",
             full_refusals, missing_removes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/dlsq_pkg.sv
rtl/dlsq_in_if.sv
rtl/dlsq_out_if.sv
rtl/dlsq_cell.sv
rtl/delta_list_sleep_queue.sv
bench/tb_delta_list_sleep_queue.sv
